@@ rtl/smsm_pkg.sv @@
// Shared types, codes and constants of the sparse matrix store and multiply core.
package smsm_pkg;

	localparam int MAX_ROWS_DEF    = 64;
	localparam int MAX_PER_ROW_DEF = 8;
	localparam int MAX_COLS        = 64;
	localparam int VEC_DEPTH       = 64;

	localparam int OP_W   = 2;
	localparam int IDX_W  = 6;
	localparam int VAL_W  = 64;
	localparam int STAT_W = 2;
	localparam int CFG_W  = 7;
	localparam int ENT_W  = IDX_W + VAL_W;

	typedef enum logic [OP_W-1:0] {
		OP_SET  = 2'd0,
		OP_GET  = 2'd1,
		OP_LOAD = 2'd2,
		OP_MUL  = 2'd3
	} op_t;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic REG_NUM_COLS = 1'b1;

	localparam logic [63:0] DEF_NAN = 64'hFFF8_0000_0000_0000;
	localparam logic [63:0] QBIT    = 64'h0008_0000_0000_0000;

	typedef enum logic {
		FOP_MUL = 1'b0,
		FOP_ADD = 1'b1
	} fpu_op_t;

	typedef struct packed {
		fpu_op_t     op;
		logic [63:0] a;
		logic [63:0] b;
	} fpu_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] result;
	} fpu_rsp_t;

	typedef enum logic [3:0] {
		FS_IDLE,
		FS_MUL,
		FS_ALIGN,
		FS_ADDSUB,
		FS_NORMR,
		FS_NORML,
		FS_DENORM,
		FS_ROUND,
		FS_DONE
	} fpu_state_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_DECIDE,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_LOAD,
		ST_MUL_ROW,
		ST_MUL_ENT,
		ST_MUL_VEC,
		ST_MUL_VWAIT,
		ST_MUL_FMUL,
		ST_MUL_FADD,
		ST_EMIT
	} ctl_state_t;

endpackage

@@ rtl/smsm_if.sv @@
// Command and result channel interfaces.
interface smsm_in_if;
	logic                          valid;
	logic                          ready;
	logic [smsm_pkg::OP_W-1:0]     operation;
	logic [smsm_pkg::IDX_W-1:0]    row_index;
	logic [smsm_pkg::IDX_W-1:0]    col_index;
	logic [smsm_pkg::VAL_W-1:0]    value_bits;

	modport source(output valid, output operation, output row_index, output col_index,
		output value_bits, input ready);
	modport sink(input valid, input operation, input row_index, input col_index,
		input value_bits, output ready);
endinterface

interface smsm_out_if;
	logic                          valid;
	logic                          ready;
	logic [smsm_pkg::VAL_W-1:0]    result_bits;
	logic [smsm_pkg::IDX_W-1:0]    result_row;
	logic [smsm_pkg::STAT_W-1:0]   status;
	logic                          last;

	modport source(output valid, output result_bits, output result_row, output status,
		output last, input ready);
	modport sink(input valid, input result_bits, input result_row, input status,
		input last, output ready);
endinterface

@@ rtl/sparse_matrix_store_and_multiply_core.sv @@
// Sparse matrix store with set/get/load and row-by-vector multiply, top level.
//
//  channel   dir   handshake          payload
//  cmd       in    valid/ready        operation, row_index, col_index, value_bits
//  res       out   valid/ready        result_bits, result_row, status, last
//  cfg       in    cfg_we             cfg_index, cfg_wdata
//
// Set/get searches the row's stored slots in turn; a set of an absent column appends it
// when the row has room, and an erase moves the later entries down. Out of range goes
// straight to the result. Multiply fetches each stored entry of each row and runs the
// bit-serial significand multiply and then the add (both short-cut when an operand is
// zero, infinite or NaN); the add normalises left in a one-bit-a-cycle loop.
// Reset clears the row-count and vector valid bits and registers; no clearing pass.
// A result waiting in the output register only stalls the next result, not intake.
module sparse_matrix_store_and_multiply_core #(
	parameter int MAX_ROWS    = smsm_pkg::MAX_ROWS_DEF,
	parameter int MAX_PER_ROW = smsm_pkg::MAX_PER_ROW_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	smsm_in_if.sink                      cmd,
	smsm_out_if.source                   res,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [smsm_pkg::CFG_W-1:0]   cfg_wdata
);

	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int IW    = $clog2(MAX_ROWS + 1);
	localparam int CW    = $clog2(MAX_PER_ROW + 1);
	localparam int DEPTH = MAX_ROWS * MAX_PER_ROW;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VW    = $clog2(smsm_pkg::VEC_DEPTH);

	smsm_pkg::ctl_state_t state_q, state_d;

	smsm_pkg::op_t                 op_q;
	logic [smsm_pkg::IDX_W-1:0]    row_q, col_q;
	logic [63:0]                   val_q;
	logic [smsm_pkg::CFG_W-1:0]    nrows_q, ncols_q;
	logic [MAX_ROWS-1:0]           cnt_vld_q;
	logic                          cnt_vld_rd_q;
	logic [smsm_pkg::VEC_DEPTH-1:0] vec_vld_q;
	logic                          vld_rd_q;
	logic [CW-1:0]                 j_q, hit_slot_q;
	logic [IW-1:0]                 i_q;
	logic                          found_q;
	logic [63:0]                   hit_val_q, acc_q, opa_q;
	logic [63:0]                   pend_bits_q;
	logic [smsm_pkg::IDX_W-1:0]    pend_row_q;
	logic [smsm_pkg::STAT_W-1:0]   pend_status_q;
	logic                          pend_last_q;
	logic                          out_valid_q;
	logic [63:0]                   out_bits_q;
	logic [smsm_pkg::IDX_W-1:0]    out_row_q;
	logic [smsm_pkg::STAT_W-1:0]   out_status_q;
	logic                          out_last_q;

	// memory and unit controls
	logic                          ent_we;
	logic [AW-1:0]                 ent_waddr, ent_raddr;
	logic [smsm_pkg::ENT_W-1:0]    ent_wdata, ent_rdata;
	logic                          vec_we;
	logic [VW-1:0]                 vec_raddr;
	logic [63:0]                   vec_rdata, vec_val;
	logic                          cnt_we;
	logic [CW-1:0]                 cnt_wdata, cnt_rdata;
	logic                          fpu_start;
	smsm_pkg::fpu_req_t            fpu_req;
	smsm_pkg::fpu_rsp_t            fpu_rsp;
	logic                          out_load, cnt_inc, cnt_dec;

	logic [smsm_pkg::CFG_W-1:0]    rows_used, cfg_rows_used;
	logic                          row_ok, col_ok, val_zero, hit;
	logic [RW-1:0]                 cur_row;
	logic [CW-1:0]                 cur_cnt;
	logic [smsm_pkg::IDX_W-1:0]    rd_col;
	logic [63:0]                   rd_val;

	function automatic logic [AW-1:0] ent_addr(input logic [RW-1:0] r, input logic [CW-1:0] s);
		return AW'(32'(r) * MAX_PER_ROW + 32'(s));
	endfunction

	always_comb begin
		rows_used     = (32'(nrows_q) < MAX_ROWS) ? nrows_q : smsm_pkg::CFG_W'(MAX_ROWS);
		cfg_rows_used = (32'(cfg_wdata) < MAX_ROWS) ? cfg_wdata : smsm_pkg::CFG_W'(MAX_ROWS);
		row_ok   = (32'(row_q) < 32'(rows_used));
		col_ok   = (32'(col_q) < 32'(ncols_q)) && (32'(col_q) < smsm_pkg::MAX_COLS);
		val_zero = (val_q[62:0] == 63'd0);
		cur_row  = (op_q == smsm_pkg::OP_MUL) ? i_q[RW-1:0] : row_q[RW-1:0];
		// count arrives in the cycle after the row settles; a cleared row reads as empty
		cur_cnt  = cnt_vld_rd_q ? cnt_rdata : '0;
		rd_col   = ent_rdata[smsm_pkg::ENT_W-1 -: smsm_pkg::IDX_W];
		rd_val   = ent_rdata[63:0];
		hit      = (rd_col == col_q);
		vec_val  = vld_rd_q ? vec_rdata : 64'd0;
		cnt_we   = cnt_inc || cnt_dec;
		cnt_wdata = cnt_inc ? (cur_cnt + CW'(1)) : (cur_cnt - CW'(1));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			smsm_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					state_d = smsm_pkg::ST_DECODE;
				end
			end
			smsm_pkg::ST_DECODE: begin
				case (op_q)
					smsm_pkg::OP_SET, smsm_pkg::OP_GET: begin
						state_d = (row_ok && col_ok) ? smsm_pkg::ST_SRCH_RD : smsm_pkg::ST_EMIT;
					end
					smsm_pkg::OP_LOAD: state_d = smsm_pkg::ST_LOAD;
					smsm_pkg::OP_MUL:  state_d = smsm_pkg::ST_MUL_ROW;
					default:           state_d = smsm_pkg::ST_IDLE;
				endcase
			end
			smsm_pkg::ST_SRCH_RD: begin
				state_d = (j_q >= cur_cnt) ? smsm_pkg::ST_DECIDE : smsm_pkg::ST_SRCH_CMP;
			end
			smsm_pkg::ST_SRCH_CMP: begin
				state_d = hit ? smsm_pkg::ST_DECIDE : smsm_pkg::ST_SRCH_RD;
			end
			smsm_pkg::ST_DECIDE: begin
				if ((op_q == smsm_pkg::OP_SET) && val_zero && found_q) begin
					state_d = smsm_pkg::ST_SHIFT_RD;
				end else begin
					state_d = smsm_pkg::ST_EMIT;
				end
			end
			smsm_pkg::ST_SHIFT_RD: begin
				if ((32'(j_q) + 1) < 32'(cur_cnt)) begin
					state_d = smsm_pkg::ST_SHIFT_WR;
				end else begin
					state_d = smsm_pkg::ST_EMIT;
				end
			end
			smsm_pkg::ST_SHIFT_WR: state_d = smsm_pkg::ST_SHIFT_RD;
			smsm_pkg::ST_LOAD:     state_d = smsm_pkg::ST_EMIT;
			smsm_pkg::ST_MUL_ROW: begin
				state_d = (32'(i_q) == 32'(rows_used)) ? smsm_pkg::ST_IDLE : smsm_pkg::ST_MUL_ENT;
			end
			smsm_pkg::ST_MUL_ENT: begin
				state_d = (j_q >= cur_cnt) ? smsm_pkg::ST_EMIT : smsm_pkg::ST_MUL_VEC;
			end
			smsm_pkg::ST_MUL_VEC:   state_d = smsm_pkg::ST_MUL_VWAIT;
			smsm_pkg::ST_MUL_VWAIT: state_d = smsm_pkg::ST_MUL_FMUL;
			smsm_pkg::ST_MUL_FMUL: begin
				if (fpu_rsp.done) begin
					state_d = smsm_pkg::ST_MUL_FADD;
				end
			end
			smsm_pkg::ST_MUL_FADD: begin
				if (fpu_rsp.done) begin
					state_d = smsm_pkg::ST_MUL_ENT;
				end
			end
			smsm_pkg::ST_EMIT: begin
				if (!out_valid_q || res.ready) begin
					state_d = (op_q == smsm_pkg::OP_MUL) ? smsm_pkg::ST_MUL_ROW : smsm_pkg::ST_IDLE;
				end
			end
			default: state_d = smsm_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd.ready = (state_q == smsm_pkg::ST_IDLE);
		ent_we    = 1'b0;
		ent_waddr = ent_addr(cur_row, j_q);
		ent_wdata = {col_q, val_q};
		ent_raddr = ent_addr(cur_row, j_q);
		vec_we    = 1'b0;
		vec_raddr = rd_col[VW-1:0];
		fpu_start = 1'b0;
		fpu_req   = '{op: smsm_pkg::FOP_MUL, a: opa_q, b: vec_val};
		out_load  = 1'b0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		case (state_q)
			smsm_pkg::ST_DECIDE: begin
				if ((op_q == smsm_pkg::OP_SET) && !val_zero) begin
					if (found_q) begin
						ent_we    = 1'b1;
						ent_waddr = ent_addr(cur_row, hit_slot_q);
					end else if (32'(cur_cnt) < MAX_PER_ROW) begin
						ent_we    = 1'b1;
						ent_waddr = ent_addr(cur_row, cur_cnt);
						cnt_inc   = 1'b1;
					end
				end
			end
			smsm_pkg::ST_SHIFT_RD: begin
				ent_raddr = ent_addr(cur_row, j_q + CW'(1));
				if (!((32'(j_q) + 1) < 32'(cur_cnt))) begin
					cnt_dec = 1'b1;
				end
			end
			smsm_pkg::ST_SHIFT_WR: begin
				ent_we    = 1'b1;
				ent_wdata = ent_rdata;
			end
			smsm_pkg::ST_LOAD: begin
				vec_we = col_ok;
			end
			smsm_pkg::ST_MUL_VWAIT: begin
				fpu_start = 1'b1;
			end
			smsm_pkg::ST_MUL_FMUL: begin
				fpu_req = '{op: smsm_pkg::FOP_ADD, a: acc_q, b: fpu_rsp.result};
				fpu_start = fpu_rsp.done;
			end
			smsm_pkg::ST_EMIT: begin
				out_load = !out_valid_q || res.ready;
			end
			default: begin
			end
		endcase
	end

	smsm_ram #(.WIDTH(smsm_pkg::ENT_W), .DEPTH(DEPTH)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	smsm_ram #(.WIDTH(64), .DEPTH(smsm_pkg::VEC_DEPTH)) u_vec_ram (
		.clk   (clk),
		.we    (vec_we),
		.waddr (col_q[VW-1:0]),
		.wdata (val_q),
		.raddr (vec_raddr),
		.rdata (vec_rdata)
	);

	smsm_ram #(.WIDTH(CW), .DEPTH(MAX_ROWS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cur_row),
		.wdata (cnt_wdata),
		.raddr (cur_row),
		.rdata (cnt_rdata)
	);

	smsm_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fpu_start),
		.req    (fpu_req),
		.rsp    (fpu_rsp)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= smsm_pkg::ST_IDLE;
			nrows_q     <= '0;
			ncols_q     <= '0;
			cnt_vld_q   <= '0;
			vec_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && (cfg_index == smsm_pkg::REG_NUM_ROWS)) begin
				nrows_q <= cfg_wdata;
				// shrinking empties the rows that fall away
				for (int r = 0; r < MAX_ROWS; r++) begin
					if (r >= 32'(cfg_rows_used)) begin
						cnt_vld_q[r] <= 1'b0;
					end
				end
			end else if (cnt_we) begin
				cnt_vld_q[cur_row] <= 1'b1;
			end
			if (cfg_we && (cfg_index == smsm_pkg::REG_NUM_COLS)) begin
				ncols_q <= cfg_wdata;
			end
			if (vec_we) begin
				vec_vld_q[col_q[VW-1:0]] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		vld_rd_q     <= vec_vld_q[vec_raddr];
		cnt_vld_rd_q <= cnt_vld_q[cur_row];
		case (state_q)
			smsm_pkg::ST_IDLE: begin
				op_q  <= smsm_pkg::op_t'(cmd.operation);
				row_q <= cmd.row_index;
				col_q <= cmd.col_index;
				val_q <= cmd.value_bits;
			end
			smsm_pkg::ST_DECODE: begin
				j_q           <= '0;
				i_q           <= '0;
				found_q       <= 1'b0;
				pend_bits_q   <= 64'd0;
				pend_row_q    <= '0;
				pend_last_q   <= 1'b1;
				pend_status_q <= (row_ok && col_ok) ? smsm_pkg::STAT_OK : smsm_pkg::STAT_RANGE;
			end
			smsm_pkg::ST_SRCH_CMP: begin
				if (hit) begin
					found_q    <= 1'b1;
					hit_slot_q <= j_q;
					hit_val_q  <= rd_val;
				end else begin
					j_q <= j_q + CW'(1);
				end
			end
			smsm_pkg::ST_DECIDE: begin
				j_q <= hit_slot_q;
				if (op_q == smsm_pkg::OP_GET) begin
					pend_bits_q <= found_q ? hit_val_q : 64'd0;
				end else if (!val_zero && !found_q && (32'(cur_cnt) >= MAX_PER_ROW)) begin
					pend_status_q <= smsm_pkg::STAT_FULL;
				end
			end
			smsm_pkg::ST_SHIFT_WR: begin
				j_q <= j_q + CW'(1);
			end
			smsm_pkg::ST_LOAD: begin
				pend_status_q <= col_ok ? smsm_pkg::STAT_OK : smsm_pkg::STAT_RANGE;
			end
			smsm_pkg::ST_MUL_ROW: begin
				acc_q <= 64'd0;
				j_q   <= '0;
			end
			smsm_pkg::ST_MUL_ENT: begin
				pend_bits_q   <= acc_q;
				pend_row_q    <= smsm_pkg::IDX_W'(i_q);
				pend_status_q <= smsm_pkg::STAT_OK;
				pend_last_q   <= ((32'(i_q) + 1) == 32'(rows_used));
			end
			smsm_pkg::ST_MUL_VEC: begin
				opa_q <= rd_val;
			end
			smsm_pkg::ST_MUL_FADD: begin
				if (fpu_rsp.done) begin
					acc_q <= fpu_rsp.result;
					j_q   <= j_q + CW'(1);
				end
			end
			smsm_pkg::ST_EMIT: begin
				if (out_load) begin
					out_bits_q   <= pend_bits_q;
					out_row_q    <= pend_row_q;
					out_status_q <= pend_status_q;
					out_last_q   <= pend_last_q;
					if (op_q == smsm_pkg::OP_MUL) begin
						i_q <= i_q + IW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid       = out_valid_q;
	assign res.result_bits = out_bits_q;
	assign res.result_row  = out_row_q;
	assign res.status      = out_status_q;
	assign res.last        = out_last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> (32'(cnt_wdata) <= MAX_PER_ROW))
		else $error("row entry count above row capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || res.ready))
		else $error("result register overwritten before transaction");
	assert property (@(posedge clk) disable iff (!arst_n)
		fpu_start |-> !fpu_rsp.busy)
		else $error("FPU started while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && pend_last_q && (op_q == smsm_pkg::OP_MUL))
		|-> ((32'(pend_row_q) + 1) == 32'(rows_used)))
		else $error("last flag on a multiply result that is not the final row");

endmodule

@@ rtl/smsm_ram.sv @@
// Generic simple dual-port RAM with registered read.
module smsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/smsm_fpu.sv @@
// Iterative double precision multiply / add unit, round to nearest even.
module smsm_fpu (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  smsm_pkg::fpu_req_t  req,
	output smsm_pkg::fpu_rsp_t  rsp
);

	smsm_pkg::fpu_state_t st_q, st_d;

	logic               sgn_q;
	logic signed [13:0] exp_q;
	logic [107:0]       man_q;
	logic [105:0]       mc_q;
	logic [52:0]        mp_q;
	logic [5:0]         cnt_q;
	logic [52:0]        sm_q;
	logic [10:0]        d_q;
	logic               sub_q;
	logic [63:0]        res_q;

	// operand decode
	logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_ge;
	logic [10:0] ea_n, eb_n;
	logic [52:0] ma, mb;
	logic        spec;
	logic [63:0] spec_res;

	always_comb begin
		sa     = req.a[63];
		sb     = req.b[63];
		a_nan  = (&req.a[62:52]) && (|req.a[51:0]);
		b_nan  = (&req.b[62:52]) && (|req.b[51:0]);
		a_inf  = (&req.a[62:52]) && !(|req.a[51:0]);
		b_inf  = (&req.b[62:52]) && !(|req.b[51:0]);
		a_zero = (req.a[62:0] == 63'd0);
		b_zero = (req.b[62:0] == 63'd0);
		ea_n   = (req.a[62:52] == 11'd0) ? 11'd1 : req.a[62:52];
		eb_n   = (req.b[62:52] == 11'd0) ? 11'd1 : req.b[62:52];
		ma     = {|req.a[62:52], req.a[51:0]};
		mb     = {|req.b[62:52], req.b[51:0]};
		a_ge   = (req.a[62:0] >= req.b[62:0]);
		spec     = 1'b1;
		spec_res = 64'd0;
		if (a_nan) begin
			spec_res = req.a | smsm_pkg::QBIT;
		end else if (b_nan) begin
			spec_res = req.b | smsm_pkg::QBIT;
		end else if (req.op == smsm_pkg::FOP_MUL) begin
			if ((a_inf && b_zero) || (a_zero && b_inf)) begin
				spec_res = smsm_pkg::DEF_NAN;
			end else if (a_inf || b_inf) begin
				spec_res = {sa ^ sb, 11'h7ff, 52'd0};
			end else if (a_zero || b_zero) begin
				spec_res = {sa ^ sb, 63'd0};
			end else begin
				spec = 1'b0;
			end
		end else begin
			if (a_inf && b_inf && (sa != sb)) begin
				spec_res = smsm_pkg::DEF_NAN;
			end else if (a_inf) begin
				spec_res = req.a;
			end else if (b_inf) begin
				spec_res = req.b;
			end else if (a_zero && b_zero) begin
				spec_res = {sa & sb, 63'd0};
			end else if (a_zero) begin
				spec_res = req.b;
			end else if (b_zero) begin
				spec_res = req.a;
			end else if ((req.a[62:0] == req.b[62:0]) && (sa != sb)) begin
				// exact cancellation gives +0
				spec_res = 64'd0;
			end else begin
				spec = 1'b0;
			end
		end
	end

	// alignment of the smaller addend, sticky folded into bit 0
	logic [105:0] al_x, al_sh;
	logic         al_lost;
	always_comb begin
		al_x    = {sm_q, 53'd0};
		al_sh   = al_x >> d_q;
		al_lost = ((al_sh << d_q) != al_x);
	end

	// right shift into the subnormal range
	logic [13:0]  dn_amt;
	logic [107:0] dn_sh;
	logic         dn_lost;
	always_comb begin
		dn_amt  = 14'd1 - 14'(exp_q);
		dn_sh   = man_q >> dn_amt;
		dn_lost = ((dn_sh << dn_amt) != man_q);
	end

	// rounding and packing
	logic               rnd_inc;
	logic [53:0]        rnd_m;
	logic [52:0]        rnd_mant;
	logic signed [13:0] rnd_e;
	logic [63:0]        rnd_res;
	always_comb begin
		rnd_inc = man_q[52] && (man_q[53] || (|man_q[51:0]));
		rnd_m   = {1'b0, man_q[105:53]} + 54'(rnd_inc);
		if (rnd_m[53]) begin
			rnd_mant = rnd_m[53:1];
			rnd_e    = exp_q + 14'sd1;
		end else begin
			rnd_mant = rnd_m[52:0];
			rnd_e    = exp_q;
		end
		if (rnd_e >= 14'sd2047) begin
			rnd_res = {sgn_q, 11'h7ff, 52'd0};
		end else if (rnd_mant[52]) begin
			rnd_res = {sgn_q, rnd_e[10:0], rnd_mant[51:0]};
		end else begin
			rnd_res = {sgn_q, 11'd0, rnd_mant[51:0]};
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			smsm_pkg::FS_IDLE, smsm_pkg::FS_DONE: begin
				if (start) begin
					if (spec) begin
						st_d = smsm_pkg::FS_DONE;
					end else if (req.op == smsm_pkg::FOP_MUL) begin
						st_d = smsm_pkg::FS_MUL;
					end else begin
						st_d = smsm_pkg::FS_ALIGN;
					end
				end else begin
					st_d = smsm_pkg::FS_IDLE;
				end
			end
			smsm_pkg::FS_MUL: begin
				if (cnt_q == 6'd52) begin
					st_d = smsm_pkg::FS_NORMR;
				end
			end
			smsm_pkg::FS_ALIGN:  st_d = smsm_pkg::FS_ADDSUB;
			smsm_pkg::FS_ADDSUB: st_d = smsm_pkg::FS_NORMR;
			smsm_pkg::FS_NORMR:  st_d = smsm_pkg::FS_NORML;
			smsm_pkg::FS_NORML: begin
				if (man_q[105] || (exp_q <= 14'sd1)) begin
					st_d = smsm_pkg::FS_DENORM;
				end
			end
			smsm_pkg::FS_DENORM: st_d = smsm_pkg::FS_ROUND;
			smsm_pkg::FS_ROUND:  st_d = smsm_pkg::FS_DONE;
			default:             st_d = smsm_pkg::FS_IDLE;
		endcase
	end

	always_comb begin
		rsp.busy   = !((st_q == smsm_pkg::FS_IDLE) || (st_q == smsm_pkg::FS_DONE));
		rsp.done   = (st_q == smsm_pkg::FS_DONE);
		rsp.result = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= smsm_pkg::FS_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			smsm_pkg::FS_IDLE, smsm_pkg::FS_DONE: begin
				if (start) begin
					res_q <= spec_res;
					cnt_q <= 6'd0;
					if (req.op == smsm_pkg::FOP_MUL) begin
						sgn_q <= sa ^ sb;
						exp_q <= 14'(ea_n) + 14'(eb_n) - 14'sd1022;
						man_q <= 108'd0;
						mc_q  <= 106'(ma);
						mp_q  <= mb;
					end else begin
						sub_q <= sa ^ sb;
						if (a_ge) begin
							sgn_q <= sa;
							exp_q <= 14'(ea_n);
							man_q <= {2'b00, ma, 53'd0};
							sm_q  <= mb;
							d_q   <= ea_n - eb_n;
						end else begin
							sgn_q <= sb;
							exp_q <= 14'(eb_n);
							man_q <= {2'b00, mb, 53'd0};
							sm_q  <= ma;
							d_q   <= eb_n - ea_n;
						end
					end
				end
			end
			smsm_pkg::FS_MUL: begin
				if (mp_q[0]) begin
					man_q <= man_q + 108'(mc_q);
				end
				mc_q  <= mc_q << 1;
				mp_q  <= mp_q >> 1;
				cnt_q <= cnt_q + 6'd1;
			end
			smsm_pkg::FS_ALIGN: begin
				mc_q <= al_sh | 106'(al_lost);
			end
			smsm_pkg::FS_ADDSUB: begin
				man_q <= sub_q ? (man_q - 108'(mc_q)) : (man_q + 108'(mc_q));
			end
			smsm_pkg::FS_NORMR: begin
				if (|man_q[107:106]) begin
					man_q <= {1'b0, man_q[107:1]} | 108'(man_q[0]);
					exp_q <= exp_q + 14'sd1;
				end
			end
			smsm_pkg::FS_NORML: begin
				if (!man_q[105] && (exp_q > 14'sd1)) begin
					man_q <= man_q << 1;
					exp_q <= exp_q - 14'sd1;
				end
			end
			smsm_pkg::FS_DENORM: begin
				if (exp_q < 14'sd1) begin
					man_q <= dn_sh | 108'(dn_lost);
					exp_q <= 14'sd1;
				end
			end
			smsm_pkg::FS_ROUND: begin
				res_q <= rnd_res;
			end
			default: begin
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == smsm_pkg::FS_MUL) |-> (cnt_q <= 6'd52))
		else $error("multiply step count overran");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == smsm_pkg::FS_ROUND) |-> (man_q[107:106] == 2'b00))
		else $error("significand not normalised before rounding");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == smsm_pkg::FS_ROUND) |-> (exp_q >= 14'sd1))
		else $error("exponent below subnormal floor at rounding");

endmodule
